// File: sv/espc_pkg.sv
package espc_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int VERTEX_BITS_DEF = 16;

    // Fixed field widths
    localparam int VTX_W     = 16;
    localparam int CNT_OUT_W = 10;
    localparam int STATUS_W  = 3;
    localparam int CMD_W     = 2;

    // Golden-ratio multiplier of the key hash
    localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PARALLEL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SELF     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VTX_W-1:0] u_index;
        logic [VTX_W-1:0] v_index;
        logic             edge_directed;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CNT_OUT_W-1:0] edges_stored;
        logic [CNT_OUT_W-1:0] directed_total;
        logic                 list_valid;
    } out_item_t;

    // One hash table slot
    typedef struct packed {
        logic             used;
        logic             dir;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic hash;
        logic addr_first;
        logic probe;
        logic probe_next;
        logic sweep;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_sweep;
        logic need_probe;
        logic probe_done;
        logic sweep_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/espc_ram.sv
module espc_ram #(
    parameter int WIDTH = espc_pkg::SLOT_W,
    parameter int DEPTH = espc_pkg::TABLE_SLOTS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/espc_ctrl.sv
module espc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  espc_pkg::dp_stat_t  stat,
    output espc_pkg::ctl_cmd_t  cmd
);
    import espc_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_ADDR   = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_SWEEP  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode state into datapath commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash = 1'b1;
                if (stat.need_sweep) begin
                    state_next = S_SWEEP;
                end else if (stat.need_probe) begin
                    state_next = S_ADDR;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_ADDR: begin
                cmd.addr_first = 1'b1;
                state_next     = S_PROBE;
            end
            S_PROBE: begin
                cmd.probe      = 1'b1;
                cmd.probe_next = !stat.probe_done;
                if (stat.probe_done) begin
                    state_next = S_FINISH;
                end
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = stat.out_free;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    // Advance state; reset starts the table clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/espc_dp.sv
module espc_dp #(
    parameter int TABLE_SLOTS = espc_pkg::TABLE_SLOTS_DEF,
    parameter int VERTEX_BITS = espc_pkg::VERTEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  espc_pkg::in_item_t  s_data,
    input  espc_pkg::ctl_cmd_t  cmd,
    output espc_pkg::dp_stat_t  stat,
    input  logic                m_ready,
    output logic                m_valid,
    output espc_pkg::out_item_t m_data
);
    import espc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS / 2 + 1);
    localparam int VB    = (VERTEX_BITS < VTX_W) ? VERTEX_BITS : VTX_W;
    localparam logic [VTX_W-1:0] VMASK = VTX_W'((64'd1 << VB) - 64'd1);
    localparam logic [CNT_W-1:0] HALF  = CNT_W'(TABLE_SLOTS / 2);

    // Item registers
    logic [CMD_W-1:0] cmd_reg;
    logic [VTX_W-1:0] a_reg;
    logic [VTX_W-1:0] b_reg;
    logic             dir_reg;
    logic             self_reg;

    // Hash partial products
    logic [15:0] p_lo_reg;
    logic [15:0] p_mid_reg;
    logic [15:0] p_a_reg;
    logic [47:0] prod_lo;
    logic [15:0] prod_mid;
    logic [15:0] prod_a;
    logic [15:0] hash_sum;

    // Probe state
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] addr_next;
    logic             hit_reg;
    logic [IDX_W-1:0] sweep_reg;

    // Set state
    logic [CNT_W-1:0] stored_reg;
    logic [CNT_W-1:0] stored_next;
    logic [CNT_W-1:0] directed_reg;
    logic [CNT_W-1:0] directed_next;
    logic             err_reg;
    logic             err_next;

    // Result
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic [STATUS_W-1:0] st;
    logic                add_write;

    // Table port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             rd_slot;
    slot_t             new_slot;
    logic              slot_match;

    // Mask and order the endpoints of the incoming item
    logic [VTX_W-1:0] u_m;
    logic [VTX_W-1:0] v_m;
    logic             swap;

    assign u_m  = s_data.u_index & VMASK;
    assign v_m  = s_data.v_index & VMASK;
    assign swap = !s_data.edge_directed && (u_m > v_m);

    // Bits 32 up of key*HASH_MUL: a*M low half plus bits 47:32 of b*M
    assign prod_lo  = 48'(b_reg) * 48'(HASH_MUL[31:0]);
    assign prod_mid = b_reg * HASH_MUL[47:32];
    assign prod_a   = a_reg * HASH_MUL[15:0];
    assign hash_sum = p_lo_reg + p_mid_reg + p_a_reg;

    // Pick the next probe address
    always_comb begin
        if (cmd.addr_first) begin
            addr_next = hash_sum[IDX_W-1:0];
        end else if (cmd.probe_next) begin
            addr_next = addr_reg + 1'b1;
        end else begin
            addr_next = addr_reg;
        end
    end

    // Compare the slot read at the current probe address
    assign rd_slot    = slot_t'(ram_rdata);
    assign slot_match = rd_slot.used && (rd_slot.dir == dir_reg)
                        && (rd_slot.a == a_reg) && (rd_slot.b == b_reg);

    // Work out the result and the next set state
    always_comb begin
        st            = ST_IGNORED;
        stored_next   = stored_reg;
        directed_next = directed_reg;
        err_next      = err_reg;
        add_write     = 1'b0;
        unique case (cmd_reg)
            CMD_CLEAR: begin
                st            = ST_CLEARED;
                stored_next   = '0;
                directed_next = '0;
                err_next      = 1'b0;
            end
            CMD_ADD: begin
                if (err_reg) begin
                    st = ST_IGNORED;
                end else if (self_reg) begin
                    st       = ST_SELF;
                    err_next = 1'b1;
                end else if (hit_reg) begin
                    st       = ST_PARALLEL;
                    err_next = 1'b1;
                end else if (stored_reg >= HALF) begin
                    st       = ST_FULL;
                    err_next = 1'b1;
                end else begin
                    st            = ST_ADDED;
                    add_write     = 1'b1;
                    stored_next   = stored_reg + 1'b1;
                    directed_next = directed_reg + CNT_W'(dir_reg);
                end
            end
            CMD_QUERY: begin
                st = hit_reg ? ST_FOUND : ST_ABSENT;
            end
            default: begin
                st = ST_IGNORED;
            end
        endcase
    end

    // Drive the table write port: clearing pass or new edge
    assign new_slot.used = 1'b1;
    assign new_slot.dir  = dir_reg;
    assign new_slot.a    = a_reg;
    assign new_slot.b    = b_reg;

    assign ram_we    = cmd.sweep || (cmd.finish && add_write);
    assign ram_waddr = cmd.sweep ? sweep_reg : addr_reg;
    assign ram_wdata = cmd.sweep ? '0 : SLOT_W'(new_slot);

    espc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    // Hold payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_data.command;
            a_reg    <= swap ? v_m : u_m;
            b_reg    <= swap ? u_m : v_m;
            dir_reg  <= s_data.edge_directed;
            self_reg <= (u_m == v_m);
        end
        if (cmd.hash) begin
            p_lo_reg  <= prod_lo[47:32];
            p_mid_reg <= prod_mid;
            p_a_reg   <= prod_a;
        end
        if (cmd.probe) begin
            hit_reg <= slot_match;
        end
        addr_reg <= addr_next;
        if (cmd.finish) begin
            m_data_reg.status         <= st;
            m_data_reg.edges_stored   <= CNT_OUT_W'(stored_next);
            m_data_reg.directed_total <= CNT_OUT_W'(directed_next);
            m_data_reg.list_valid     <= !err_next;
        end
    end

    // Advance counters, error flag and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg    <= '0;
            stored_reg   <= '0;
            directed_reg <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.sweep) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.finish) begin
                stored_reg   <= stored_next;
                directed_reg <= directed_next;
                err_reg      <= err_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Report status to the controller
    assign stat.need_sweep = (cmd_reg == CMD_CLEAR);
    assign stat.need_probe = (cmd_reg == CMD_QUERY)
                             || ((cmd_reg == CMD_ADD) && !err_reg && !self_reg);
    assign stat.probe_done = !rd_slot.used || slot_match;
    assign stat.sweep_last = (sweep_reg == {IDX_W{1'b1}});
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= HALF)
        else $error("stored edge count exceeds half the table");

    a_dir_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        directed_reg <= stored_reg)
        else $error("directed count exceeds stored count");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result raised without a finish step");

    a_add_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && add_write) |=> (stored_reg == $past(stored_reg) + 1'b1))
        else $error("stored edge count did not advance on add");

endmodule

// File: sv/edge_set_parallel_check.sv
// An add or query is hashed, then probes table slots from the hash address, one slot
// read per cycle, up to an unused or matching slot, and then its result is registered.
// Items needing no probe (add after error, self loop, unused command) skip the probe.
// Clear sweeps every slot. A new item is taken only after the last result is registered;
// a result waits while an earlier one is still unread. Reset (aresetn low, synchronous)
// zeroes counts and error flag, then runs a clearing pass over the table before the first item is taken.
module edge_set_parallel_check #(
    parameter int TABLE_SLOTS = espc_pkg::TABLE_SLOTS_DEF,
    parameter int VERTEX_BITS = espc_pkg::VERTEX_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  espc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output espc_pkg::out_item_t m_data
);
    import espc_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    espc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    espc_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
